[design/hnfm_pkg.sv]
package hnfm_pkg;

    localparam int FINGERPRINT_WORDS_DEF = 64;
    localparam int TRACK_UNITS_DEF       = 3024;

    localparam int WORD_W   = 64;
    localparam int INDEX_W  = 6;
    localparam int ENTRY_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int DIST_W   = 13;
    localparam int TRACK_W  = 33;
    localparam int POP_W    = 7;
    localparam int RECIP_W  = 33;
    localparam int PROD_W   = ENTRY_W + RECIP_W;

    localparam logic [DIST_W-1:0]  DIST_MAX         = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
    localparam logic [DIST_W-1:0]  THRESHOLD_RESET  = 13'd4096;
    localparam logic [TRACK_W-1:0] TRACK_NONE       = '1;

    // item kinds
    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_CAND  = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]  word_data;
        logic [ENTRY_W-1:0] table_entry;
        logic [COUNT_W-1:0] candidate_count;
    } t_in_item;

    typedef struct packed {
        logic signed [TRACK_W-1:0] track_index;
        logic [DIST_W-1:0]         best_distance;
    } t_out_item;

    // distance stage record handed to the judge
    typedef struct packed {
        logic [1:0]         kind;
        logic               first;
        logic               last;
        logic [POP_W-1:0]   pop;
        logic [PROD_W-1:0]  product;
        logic [COUNT_W-1:0] count;
    } t_dist_stage;

    // adder tree: pairs, nibbles, bytes, halves, then the two words
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] s2;
        logic [WORD_W-1:0] s4;
        logic [WORD_W-1:0] s8;
        logic [WORD_W-1:0] s16;
        logic [WORD_W-1:0] s32;
        s2  = (x & 64'h5555_5555_5555_5555) + ((x >> 1) & 64'h5555_5555_5555_5555);
        s4  = (s2 & 64'h3333_3333_3333_3333) + ((s2 >> 2) & 64'h3333_3333_3333_3333);
        s8  = (s4 & 64'h0F0F_0F0F_0F0F_0F0F) + ((s4 >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
        s16 = (s8 & 64'h00FF_00FF_00FF_00FF) + ((s8 >> 8) & 64'h00FF_00FF_00FF_00FF);
        s32 = (s16 & 64'h0000_FFFF_0000_FFFF) + ((s16 >> 16) & 64'h0000_FFFF_0000_FFFF);
        return POP_W'((s32 & 64'h0000_0000_FFFF_FFFF) + (s32 >> 32));
    endfunction

endpackage

[design/hamming_nearest_fingerprint_match.sv]
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_item   (hnfm_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready   o_out_item  (hnfm_pkg::t_out_item)
// cfg       input      i_cfg_we (no wait)          i_cfg_wdata (match threshold)
//
// One item per cycle while the input is not stalled; the item completing the run passes
// the query-store, distance and output registers before its result is valid.
// Pipeline: query-store read, popcount plus reciprocal multiply, accumulate and judge.
// Synchronous active-low reset clears the run, sets the threshold to 4096 and leaves
// the query store unwritten.
// The input stalls only when a result must be written while the output register
// still holds one that has not been taken.
module hamming_nearest_fingerprint_match #(
    parameter int TRACK_UNITS       = hnfm_pkg::TRACK_UNITS_DEF,
    parameter int FINGERPRINT_WORDS = hnfm_pkg::FINGERPRINT_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hnfm_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hnfm_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [hnfm_pkg::DIST_W-1:0]    i_cfg_wdata
);
    logic                        advance;
    logic                        accept;
    logic                        a_valid;
    hnfm_pkg::t_in_item          a_item;
    logic [hnfm_pkg::WORD_W-1:0] a_qword;
    logic                        b_valid;
    hnfm_pkg::t_dist_stage       b_stage;

    // the whole pipeline moves together; bubbles travel with it
    assign o_in_ready = advance;
    assign accept     = i_in_valid && advance;

    // stage 1: write query words, read the matching query word for candidates
    hnfm_qstore #(
        .FINGERPRINT_WORDS(FINGERPRINT_WORDS)
    ) u_qstore (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_valid  (a_valid),
        .o_item   (a_item),
        .o_qword  (a_qword)
    );

    // stage 2: word distance and entry times reciprocal of the track size
    hnfm_dist #(
        .TRACK_UNITS       (TRACK_UNITS),
        .FINGERPRINT_WORDS (FINGERPRINT_WORDS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_valid  (a_valid),
        .i_item   (a_item),
        .i_qword  (a_qword),
        .o_valid  (b_valid),
        .o_stage  (b_stage)
    );

    // stage 3: accumulate, keep the running best, emit when the count is reached
    hnfm_judge #(
        .TRACK_UNITS(TRACK_UNITS)
    ) u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (b_valid),
        .i_stage     (b_stage),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // input held back only while a result waits at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    // a track index is either none or a plain unsigned quotient
    a_track_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.track_index[hnfm_pkg::TRACK_W-1] ||
                         o_out_item.track_index == hnfm_pkg::TRACK_NONE))
        else $error("malformed track index");

    // no result directly out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif
endmodule

[design/hnfm_qstore.sv]
module hnfm_qstore #(
    parameter int FINGERPRINT_WORDS = hnfm_pkg::FINGERPRINT_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_accept,
    input  hnfm_pkg::t_in_item             i_item,
    output logic                           o_valid,
    output hnfm_pkg::t_in_item             o_item,
    output logic [hnfm_pkg::WORD_W-1:0]    o_qword
);
    localparam int AW = (FINGERPRINT_WORDS > 1) ? $clog2(FINGERPRINT_WORDS) : 1;

    logic [hnfm_pkg::WORD_W-1:0] r_mem [FINGERPRINT_WORDS];
    logic                        r_valid;
    hnfm_pkg::t_in_item          r_item;
    logic [hnfm_pkg::WORD_W-1:0] r_qword;
    logic                        in_range;
    logic                        n_valid;

    assign in_range = 32'(i_item.word_index) < 32'(FINGERPRINT_WORDS);

    // only candidate words in range and counts go further down
    always_comb begin
        n_valid = 1'b0;
        if (i_accept) begin
            if (i_item.kind == hnfm_pkg::KIND_CAND) begin
                n_valid = in_range;
            end else if (i_item.kind == hnfm_pkg::KIND_COUNT) begin
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_item.kind == hnfm_pkg::KIND_QUERY && in_range) begin
            r_mem[i_item.word_index[AW-1:0]] <= i_item.word_data;
        end
        if (i_en && in_range) begin
            r_qword <= r_mem[i_item.word_index[AW-1:0]];
        end
        if (i_en) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_qword = r_qword;
endmodule

[design/hnfm_dist.sv]
module hnfm_dist #(
    parameter int TRACK_UNITS       = hnfm_pkg::TRACK_UNITS_DEF,
    parameter int FINGERPRINT_WORDS = hnfm_pkg::FINGERPRINT_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  hnfm_pkg::t_in_item             i_item,
    input  logic [hnfm_pkg::WORD_W-1:0]    i_qword,
    output logic                           o_valid,
    output hnfm_pkg::t_dist_stage          o_stage
);
    localparam int L = $clog2(TRACK_UNITS);
    // rounded-up reciprocal: exact quotient for every 32-bit entry
    localparam logic [63:0] RECIP64 =
        ((64'd1 << (32 + L)) + 64'(TRACK_UNITS) - 64'd1) / 64'(TRACK_UNITS);
    localparam logic [hnfm_pkg::RECIP_W-1:0] RECIP = RECIP64[hnfm_pkg::RECIP_W-1:0];

    logic                  r_valid;
    hnfm_pkg::t_dist_stage r_stage;
    hnfm_pkg::t_dist_stage n_stage;

    always_comb begin
        n_stage.kind    = i_item.kind;
        n_stage.first   = (i_item.word_index == '0);
        n_stage.last    = 32'(i_item.word_index) == 32'(FINGERPRINT_WORDS - 1);
        n_stage.pop     = hnfm_pkg::popcount64(i_qword ^ i_item.word_data);
        n_stage.product = hnfm_pkg::PROD_W'(i_item.table_entry) *
                          hnfm_pkg::PROD_W'(RECIP);
        n_stage.count   = i_item.candidate_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

[design/hnfm_judge.sv]
module hnfm_judge #(
    parameter int TRACK_UNITS = hnfm_pkg::TRACK_UNITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  hnfm_pkg::t_dist_stage           i_stage,
    input  logic                            i_cfg_we,
    input  logic [hnfm_pkg::DIST_W-1:0]     i_cfg_wdata,
    input  logic                            i_out_ready,
    output logic                            o_advance,
    output logic                            o_out_valid,
    output hnfm_pkg::t_out_item             o_out_item
);
    localparam int L = $clog2(TRACK_UNITS);

    logic [hnfm_pkg::DIST_W-1:0]  r_threshold;
    logic [hnfm_pkg::DIST_W-1:0]  r_partial;
    logic [hnfm_pkg::DIST_W-1:0]  r_min;
    logic [hnfm_pkg::TRACK_W-1:0] r_best;
    logic [hnfm_pkg::COUNT_W-1:0] r_processed;
    logic [hnfm_pkg::COUNT_W-1:0] r_target;
    logic                         r_known;
    logic                         r_out_valid;
    hnfm_pkg::t_out_item          r_out_item;

    logic [hnfm_pkg::DIST_W-1:0]  n_partial;
    logic [hnfm_pkg::DIST_W-1:0]  n_min;
    logic [hnfm_pkg::TRACK_W-1:0] n_best;
    logic [hnfm_pkg::COUNT_W-1:0] n_processed;
    logic [hnfm_pkg::COUNT_W-1:0] n_target;
    logic                         n_known;
    logic [hnfm_pkg::DIST_W:0]    sum;
    logic [hnfm_pkg::DIST_W-1:0]  cand_dist;
    logic [hnfm_pkg::ENTRY_W-1:0] quotient;
    logic                         emit;
    logic                         fire;

    always_comb begin
        n_partial   = r_partial;
        n_min       = r_min;
        n_best      = r_best;
        n_processed = r_processed;
        n_target    = r_target;
        n_known     = r_known;
        sum         = (hnfm_pkg::DIST_W + 1)'(r_partial) +
                      (hnfm_pkg::DIST_W + 1)'(i_stage.pop);
        quotient    = hnfm_pkg::ENTRY_W'(i_stage.product >> (32 + L));

        if (i_stage.first) begin
            cand_dist = hnfm_pkg::DIST_W'(i_stage.pop);
        end else if (sum[hnfm_pkg::DIST_W]) begin
            cand_dist = hnfm_pkg::DIST_MAX;
        end else begin
            cand_dist = sum[hnfm_pkg::DIST_W-1:0];
        end

        if (i_stage.kind == hnfm_pkg::KIND_CAND) begin
            n_partial = cand_dist;
            if (i_stage.last) begin
                // ties go to the later candidate
                if (cand_dist <= r_min) begin
                    n_min  = cand_dist;
                    n_best = hnfm_pkg::TRACK_W'(quotient);
                end
                n_partial = '0;
                if (r_processed != hnfm_pkg::COUNT_MAX) begin
                    n_processed = r_processed + 1'b1;
                end
            end
        end else if (!r_known) begin
            n_target = i_stage.count;
            n_known  = 1'b1;
        end

        emit      = i_valid && n_known && (n_processed >= n_target);
        o_advance = !(emit && r_out_valid && !i_out_ready);
        fire      = i_valid && o_advance;
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_item.track_index   <= n_best;
            r_out_item.best_distance <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= hnfm_pkg::THRESHOLD_RESET;
            r_partial   <= '0;
            r_min       <= hnfm_pkg::THRESHOLD_RESET;
            r_best      <= hnfm_pkg::TRACK_NONE;
            r_processed <= '0;
            r_target    <= '0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_target <= n_target;
                if (emit) begin
                    // clear the run
                    r_partial   <= '0;
                    r_min       <= r_threshold;
                    r_best      <= hnfm_pkg::TRACK_NONE;
                    r_processed <= '0;
                    r_known     <= 1'b0;
                end else begin
                    r_partial   <= n_partial;
                    r_min       <= n_min;
                    r_best      <= n_best;
                    r_processed <= n_processed;
                    r_known     <= n_known;
                end
            end
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
                if (r_processed == '0) begin
                    r_min <= i_cfg_wdata;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule
